// ===== design/http_connect_request_parser_macros.svh =====
// Assertion macros shared by the request line parser checks.
// Each macro expects clk_i, and HCRP_ASSERT_RST also rst_ni, to be visible where it is used.
`ifndef HTTP_CONNECT_REQUEST_PARSER_MACROS_SVH
`define HTTP_CONNECT_REQUEST_PARSER_MACROS_SVH

// Check on every clock edge once reset is released.
`define HCRP_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check on every clock edge, reset included.
`define HCRP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

// ===== design/hcrp_pkg.sv =====
// Shared types, codes and character constants of the request line parser.
// No dependencies; the parser, step and checker files refer to it by scoped names.
package hcrp_pkg;

  typedef enum logic [2:0] {
    KIND_DATA     = 3'd0,
    KIND_EOS      = 3'd1,
    KIND_LINK_ERR = 3'd2,
    KIND_TIMEOUT  = 3'd3,
    KIND_RESTART  = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    RK_HOST   = 2'd0,
    RK_ACCEPT = 2'd1,
    RK_REJECT = 2'd2
  } result_kind_e;

  typedef enum logic [2:0] {
    WHY_NONE       = 3'd0,
    WHY_BAD_PREFIX = 3'd1,
    WHY_EARLY_END  = 3'd2,
    WHY_TOO_LONG   = 3'd3,
    WHY_ERROR      = 3'd4,
    WHY_EMPTY_HOST = 3'd5
  } reason_e;

  typedef enum logic [2:0] {
    PH_PREFIX = 3'b001,
    PH_HOST   = 3'b010,
    PH_REST   = 3'b100
  } phase_e;

  localparam logic [7:0]  CHAR_SP      = 8'h20;
  localparam logic [7:0]  CHAR_CR      = 8'h0d;
  localparam logic [7:0]  CHAR_LF      = 8'h0a;
  localparam logic [3:0]  PREFIX_LAST  = 4'd7;
  localparam logic [2:0]  TERM_DONE    = 3'd4;
  localparam logic [15:0] MAX_BYTES_RESET = 16'd4096;

  typedef struct packed {
    phase_e     phase;
    logic [3:0] prefix_idx;
    logic [2:0] term_prog;
    logic       host_seen;
    logic       finished;
  } state_t;

  localparam state_t STATE_RESET = '{
    phase:      PH_PREFIX,
    prefix_idx: 4'd0,
    term_prog:  3'd0,
    host_seen:  1'b0,
    finished:   1'b0
  };

  typedef struct packed {
    result_kind_e result_kind;
    logic [7:0]   host_byte;
    reason_e      reject_reason;
  } result_t;

  // Expected character of "CONNECT " at a given position.
  function automatic logic [7:0] connect_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h43; // C
      3'd1:    c = 8'h4f; // O
      3'd2:    c = 8'h4e; // N
      3'd3:    c = 8'h4e; // N
      3'd4:    c = 8'h45; // E
      3'd5:    c = 8'h43; // C
      3'd6:    c = 8'h54; // T
      default: c = CHAR_SP;
    endcase
    return c;
  endfunction

  // Expected character of the CR LF CR LF terminator at a given position.
  function automatic logic [7:0] term_char(input logic [1:0] idx);
    return idx[0] ? CHAR_LF : CHAR_CR;
  endfunction

endpackage

// ===== design/hcrp_if.sv =====
// Handshake channel interfaces of the request line parser: input words,
// result words and the configuration write channel. Depends on nothing.
interface hcrp_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] data_byte;
  modport source (output valid, kind, data_byte, input ready);
  modport sink (input valid, kind, data_byte, output ready);
endinterface

interface hcrp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  logic [7:0] host_byte;
  logic [2:0] reject_reason;
  modport source (output valid, result_kind, host_byte, reject_reason, input ready);
  modport sink (input valid, result_kind, host_byte, reject_reason, output ready);
endinterface

interface hcrp_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== design/http_connect_request_parser.sv =====
// Request line parser for HTTP CONNECT: top level with input and result registers.
// Depends on hcrp_pkg, the hcrp_*_if interfaces and hcrp_step.
//
// Usage:
//   in_i   carries one word per request event: a data byte, end of stream,
//          link error, timeout or restart. A word is taken when valid and
//          ready are both high at a rising clock edge.
//   out_o  carries host:port bytes as they arrive, then one verdict word
//          (accept, or reject with its reason). Host bytes count only if
//          the verdict accepts.
//   cfg_i  writes max_request_bytes; always ready. Write it only while no
//          word is in flight.
// Path: a word is held in the input register and its result, if any, is
//   loaded into the result register that drives out_o.
// Throughput: one word per cycle while out_o is not stalled; the state update
//   between the input register and the result register is combinational.
// Reset: parser state cleared to prefix matching, limit back to 4096,
//   both channels empty.
// Stall: while a result waits on out_o, the input register holds its word
//   and in_i.ready drops once that register is full; nothing is dropped.
module http_connect_request_parser #(
  parameter int COUNT_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  hcrp_in_if.sink     in_i,
  hcrp_cfg_if.sink    cfg_i,
  hcrp_out_if.source  out_o
);

  // Input register stage.
  logic       in_valid_q;
  logic [2:0] in_kind_q;
  logic [7:0] in_byte_q;

  // Parser state.
  hcrp_pkg::state_t      st_q, st_d;
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic [15:0]           max_bytes_q;

  // Result register.
  logic              out_valid_q;
  hcrp_pkg::result_t out_q;

  logic              res_valid;
  hcrp_pkg::result_t res;
  logic              advance;
  logic              in_ready;

  // Move the held word on whenever the result register is free or drains.
  assign advance  = !out_valid_q || out_o.ready;
  assign in_ready = !in_valid_q || advance;

  assign in_i.ready  = in_ready;
  assign cfg_i.ready = 1'b1;

  hcrp_step #(
    .COUNT_BITS (COUNT_BITS)
  ) u_step (
    .st_i        (st_q),
    .count_i     (count_q),
    .kind_i      (in_kind_q),
    .byte_i      (in_byte_q),
    .max_bytes_i (max_bytes_q),
    .st_o        (st_d),
    .count_o     (count_d),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Input register: load a word whenever there is room.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      in_kind_q <= in_i.kind;
      in_byte_q <= in_i.data_byte;
    end
  end

  // Limit register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_bytes_q <= hcrp_pkg::MAX_BYTES_RESET;
    end else if (cfg_i.valid) begin
      max_bytes_q <= cfg_i.data;
    end
  end

  // Commit the parser state as the held word advances.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= hcrp_pkg::STATE_RESET;
      count_q <= '0;
    end else if (in_valid_q && advance) begin
      st_q    <= st_d;
      count_q <= count_d;
    end
  end

  // Result register: drop the old word when taken, load the new result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q && res_valid) begin
      out_q <= res;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.result_kind   = out_q.result_kind;
  assign out_o.host_byte     = out_q.host_byte;
  assign out_o.reject_reason = out_q.reject_reason;

endmodule

// ===== design/hcrp_step.sv =====
// Per-word decision logic of the request line parser: next state and result.
// Depends on hcrp_pkg.
module hcrp_step #(
  parameter int COUNT_BITS = 16
) (
  input  hcrp_pkg::state_t        st_i,
  input  logic [COUNT_BITS-1:0]   count_i,
  input  logic [2:0]              kind_i,
  input  logic [7:0]              byte_i,
  input  logic [15:0]             max_bytes_i,
  output hcrp_pkg::state_t        st_o,
  output logic [COUNT_BITS-1:0]   count_o,
  output logic                    res_valid_o,
  output hcrp_pkg::result_t       res_o
);

  localparam int LimW = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  hcrp_pkg::state_t      st_n;
  logic [COUNT_BITS-1:0] cnt_n;
  logic                  vld;
  hcrp_pkg::result_t     res;
  logic                  is_host;
  logic                  bad_prefix;
  logic                  too_long;

  always_comb begin
    st_n       = st_i;
    cnt_n      = count_i;
    vld        = 1'b0;
    res        = '{result_kind: hcrp_pkg::RK_HOST, host_byte: 8'd0,
                   reject_reason: hcrp_pkg::WHY_NONE};
    is_host    = 1'b0;
    bad_prefix = 1'b0;
    too_long   = 1'b0;
    case (hcrp_pkg::kind_e'(kind_i))
      hcrp_pkg::KIND_RESTART: begin
        st_n  = hcrp_pkg::STATE_RESET;
        cnt_n = '0;
      end
      hcrp_pkg::KIND_EOS: begin
        if (!st_i.finished) begin
          st_n.finished     = 1'b1;
          vld               = 1'b1;
          res.result_kind   = hcrp_pkg::RK_REJECT;
          res.reject_reason = hcrp_pkg::WHY_EARLY_END;
        end
      end
      hcrp_pkg::KIND_LINK_ERR, hcrp_pkg::KIND_TIMEOUT: begin
        if (!st_i.finished) begin
          st_n.finished     = 1'b1;
          vld               = 1'b1;
          res.result_kind   = hcrp_pkg::RK_REJECT;
          res.reject_reason = hcrp_pkg::WHY_ERROR;
        end
      end
      hcrp_pkg::KIND_DATA: begin
        if (!st_i.finished) begin
          case (st_i.phase)
            hcrp_pkg::PH_PREFIX: begin
              if (byte_i != hcrp_pkg::connect_char(st_i.prefix_idx[2:0])) begin
                bad_prefix = 1'b1;
              end else begin
                st_n.prefix_idx = st_i.prefix_idx + 4'd1;
                if (st_i.prefix_idx == hcrp_pkg::PREFIX_LAST) begin
                  st_n.phase = hcrp_pkg::PH_HOST;
                end
              end
            end
            hcrp_pkg::PH_HOST: begin
              if (byte_i == hcrp_pkg::CHAR_SP || byte_i == hcrp_pkg::CHAR_CR) begin
                st_n.phase = hcrp_pkg::PH_REST;
              end else begin
                is_host        = 1'b1;
                st_n.host_seen = 1'b1;
              end
            end
            default: begin
            end
          endcase

          if (bad_prefix) begin
            st_n              = st_i;
            st_n.finished     = 1'b1;
            vld               = 1'b1;
            res.result_kind   = hcrp_pkg::RK_REJECT;
            res.reject_reason = hcrp_pkg::WHY_BAD_PREFIX;
          end else begin
            // Saturate the byte counter at all ones.
            if (count_i != {COUNT_BITS{1'b1}}) begin
              cnt_n = count_i + COUNT_BITS'(1);
            end
            if (byte_i == hcrp_pkg::term_char(st_i.term_prog[1:0])) begin
              st_n.term_prog = st_i.term_prog + 3'd1;
            end else begin
              st_n.term_prog = (byte_i == hcrp_pkg::CHAR_CR) ? 3'd1 : 3'd0;
            end
            too_long = (LimW'(cnt_n) >= LimW'(max_bytes_i)) ||
                       (cnt_n == {COUNT_BITS{1'b1}});

            if (st_n.term_prog == hcrp_pkg::TERM_DONE) begin
              st_n.finished = 1'b1;
              vld           = 1'b1;
              if (!st_n.host_seen) begin
                res.result_kind   = hcrp_pkg::RK_REJECT;
                res.reject_reason = hcrp_pkg::WHY_EMPTY_HOST;
              end else begin
                res.result_kind = hcrp_pkg::RK_ACCEPT;
              end
            end else if (too_long) begin
              st_n.finished     = 1'b1;
              vld               = 1'b1;
              res.result_kind   = hcrp_pkg::RK_REJECT;
              res.reject_reason = hcrp_pkg::WHY_TOO_LONG;
            end else if (is_host) begin
              vld           = 1'b1;
              res.host_byte = byte_i;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign st_o        = st_n;
  assign count_o     = cnt_n;
  assign res_valid_o = vld;
  assign res_o       = res;

endmodule

// ===== design/hcrp_checker.sv =====
// Port-level checks of the request line parser, bound to its top level.
// Depends on hcrp_pkg and http_connect_request_parser_macros.svh.
`include "http_connect_request_parser_macros.svh"

module hcrp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [1:0] result_kind_i,
  input logic [7:0] host_byte_i,
  input logic [2:0] reject_reason_i
);

  // A result word that appears from an empty output came from a word taken in through the input register.
  `HCRP_ASSERT_RST(a_rise_needs_input, $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2), "result appeared without an input word")

  // The input side only backs up behind a stalled output.
  `HCRP_ASSERT_ALWAYS(a_ready_low_only_on_stall, !in_ready_i |-> (out_valid_i && !out_ready_i), "input stalled while output free")

  // A stalled result word holds.
  `HCRP_ASSERT_RST(a_out_hold, (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable({result_kind_i, host_byte_i, reject_reason_i})), "stalled result changed")

  // A host byte is never a delimiter and carries no reason.
  `HCRP_ASSERT_RST(a_host_byte_clean, (out_valid_i && result_kind_i == hcrp_pkg::RK_HOST) |-> (host_byte_i != hcrp_pkg::CHAR_SP && host_byte_i != hcrp_pkg::CHAR_CR && reject_reason_i == hcrp_pkg::WHY_NONE), "bad host byte word")

endmodule

bind http_connect_request_parser hcrp_checker u_hcrp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .result_kind_i   (out_o.result_kind),
  .host_byte_i     (out_o.host_byte),
  .reject_reason_i (out_o.reject_reason)
);
